@@ rtl/sawbc_pkg.sv @@
// Shared types and codes for the set-associative write-back cache.
// No dependencies.
package sawbc_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    localparam logic [2:0] KIND_RDATA = 3'd0;
    localparam logic [2:0] KIND_WACK  = 3'd1;
    localparam logic [2:0] KIND_BUSY  = 3'd2;
    localparam logic [2:0] KIND_WB    = 3'd3;
    localparam logic [2:0] KIND_FETCH = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [3:0]  size_bytes;
        logic [63:0] wr_data;
        logic [7:0]  req_id;
        logic [63:0] fill_word;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  resp_id;
        logic [63:0] read_data;
        logic [31:0] mem_addr;
        logic [63:0] mem_word;
        logic        last;
    } rsp_t;

endpackage

@@ rtl/sawbc_vict.sv @@
// Replacement way generator: 16-bit Galois LFSR and a constant-modulus residue unit.
// No package dependencies.
module sawbc_vict #(
    parameter int WAYS = 4,
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    output logic [WAY_W-1:0] way
);

    function automatic logic [15:0] lfsr_adv(input logic [15:0] v);
        logic [15:0] r;
        r = {1'b0, v[15:1]};
        if (v[0])
        begin
            r = r ^ 16'hB400;
        end
        return r;
    endfunction

    // v mod WAYS: sum the residues of the set bits, then reduce by shifted compare and subtract
    function automatic logic [WAY_W-1:0] mod_ways(input logic [15:0] v);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                acc = acc + 8'((32'd1 << i) % WAYS);
            end
        end
        for (int k = 3; k >= 0; k--)
        begin
            if (acc >= 8'(WAYS << k))
            begin
                acc = acc - 8'(WAYS << k);
            end
        end
        return WAY_W'(acc);
    endfunction

    logic [15:0]      lfsr_reg;
    logic [WAY_W-1:0] way_reg;

    // way_reg holds (next LFSR value) mod WAYS; a step reaches it via lfsr_reg, then way_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= 16'hFFFF;
            way_reg  <= mod_ways(lfsr_adv(16'hFFFF));
        end
        else
        begin
            if (step)
            begin
                lfsr_reg <= lfsr_adv(lfsr_reg);
            end
            way_reg <= mod_ways(lfsr_adv(lfsr_reg));
        end
    end

    assign way = way_reg;

endmodule

@@ rtl/set_assoc_write_back_cache.sv @@
// Top level of the blocking set-associative write-back cache.
// Depends on sawbc_pkg and sawbc_vict.
//
// A word is accepted when start is high and busy is low; each result appears on rsp for
// one cycle with done high and cannot be held off. A read or write hit passes through
// tag read, data read, and merge and respond before the next accept. A read or write
// while a line fetch is outstanding is refused in the cycle after accept. A clean-victim
// miss issues its fetch from the lookup state; an all-dirty miss streams LINE_BYTES/8
// writeback words, one per cycle, then the fetch. Each fill word is written when it is
// accepted; the last one then passes read-back and access to end the saved request.
module set_assoc_write_back_cache #(
    parameter int CACHE_BYTES = 4096,
    parameter int LINE_BYTES  = 32,
    parameter int WAYS        = 4,
    parameter int ADDR_BITS   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sawbc_pkg::req_t  req,
    output logic             busy,
    output logic             done,
    output sawbc_pkg::rsp_t  rsp
);
    import sawbc_pkg::*;

    localparam int NLINES  = CACHE_BYTES / LINE_BYTES;
    localparam int WPL     = LINE_BYTES / 8;
    localparam int NSETS   = NLINES / WAYS;
    localparam int LOFF    = $clog2(LINE_BYTES);
    localparam int SETB    = $clog2(NSETS);
    localparam int AW      = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TAG_W   = AW - LOFF - SETB;
    localparam int SET_W   = (SETB > 0) ? SETB : 1;
    localparam int WIDX_W  = (WPL > 1) ? $clog2(WPL) : 1;
    localparam int LINE_W  = $clog2(NLINES);
    localparam int DADDR_W = $clog2(NLINES * WPL);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [31:0] AMASK = (AW == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << AW) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_ACC, ST_WB, ST_FETCH, ST_FRD
    } state_t;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
        return SET_W'((a >> LOFF) & 32'(NSETS - 1));
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
        return TAG_W'(a >> (LOFF + SETB));
    endfunction

    function automatic logic [WIDX_W-1:0] widx_of(input logic [31:0] a);
        return WIDX_W'((a >> 3) & 32'(WPL - 1));
    endfunction

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return LINE_W'(32'(s) * WAYS + 32'(w));
    endfunction

    function automatic logic [DADDR_W-1:0] daddr(input logic [LINE_W-1:0] l,
                                                 input logic [WIDX_W-1:0] i);
        return DADDR_W'(32'(l) * WPL + 32'(i));
    endfunction

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic                pend_reg, pend_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic [WIDX_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [WIDX_W-1:0]   wb_cnt_reg, wb_cnt_next;
    logic [NLINES-1:0]   valid_reg, valid_next;
    logic [NLINES-1:0]   dirty_reg, dirty_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [TAG_W-1:0]    tag_mem [NSETS][WAYS];
    logic [TAG_W-1:0]    tag_rd_reg [WAYS];
    logic [63:0]         data_mem [NLINES * WPL];
    logic [63:0]         data_rd_reg;

    logic                tag_re, tag_we;
    logic                data_re, data_we;
    logic [DADDR_W-1:0]  data_raddr, data_waddr;
    logic [63:0]         data_wdata;

    logic                vict_step;
    logic [WAY_W-1:0]    vict_way;

    logic [SET_W-1:0]    cur_set;
    logic [TAG_W-1:0]    cur_tag;
    logic [WAYS-1:0]     hit_vec;
    logic                hit, all_dirty;
    logic [WAY_W-1:0]    hit_way, clean_way;
    logic [3:0]          n_req, n_lim, n_eff;
    logic [2:0]          bstart;
    logic [63:0]         rd_shift, wd_shift, rd_bytes, merged;
    logic [31:0]         wb_addr;

    sawbc_vict #(.WAYS(WAYS)) u_vict (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (vict_step),
        .way   (vict_way)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = rsp_valid_reg;
    assign rsp  = rsp_reg;

    // lookup and byte lane logic on the in-flight request
    always_comb
    begin
        cur_set   = set_of(req_reg.address);
        cur_tag   = tag_of(req_reg.address);
        hit       = 1'b0;
        hit_way   = '0;
        all_dirty = 1'b1;
        clean_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = (valid_reg[line_of(cur_set, WAY_W'(w))] ||
                          dirty_reg[line_of(cur_set, WAY_W'(w))]) &&
                         (tag_rd_reg[w] == cur_tag);
            if (hit_vec[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!dirty_reg[line_of(cur_set, WAY_W'(w))])
            begin
                all_dirty = 1'b0;
                clean_way = WAY_W'(w);
            end
        end

        bstart = req_reg.address[2:0];
        if (req_reg.size_bytes == 4'd0)
            n_req = 4'd1;
        else if (req_reg.size_bytes > 4'd8)
            n_req = 4'd8;
        else
            n_req = req_reg.size_bytes;
        n_lim    = 4'd8 - {1'b0, bstart};
        n_eff    = (n_req > n_lim) ? n_lim : n_req;
        rd_shift = data_rd_reg >> {bstart, 3'b000};
        wd_shift = req_reg.wr_data << {bstart, 3'b000};
        for (int j = 0; j < 8; j++)
        begin
            rd_bytes[8*j +: 8] = (4'(j) < n_eff) ? rd_shift[8*j +: 8] : 8'h00;
            merged[8*j +: 8]   = ((4'(j) >= {1'b0, bstart}) &&
                                  (4'(j) < {1'b0, bstart} + n_eff)) ?
                                 wd_shift[8*j +: 8] : data_rd_reg[8*j +: 8];
        end

        wb_addr = ((32'(tag_rd_reg[way_reg]) << (LOFF + SETB)) |
                   (32'(cur_set) << LOFF)) & AMASK;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        pend_next      = pend_reg;
        line_next      = line_reg;
        way_next       = way_reg;
        fill_cnt_next  = fill_cnt_reg;
        wb_cnt_next    = wb_cnt_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = '0;
        tag_re         = 1'b0;
        tag_we         = 1'b0;
        data_re        = 1'b0;
        data_raddr     = '0;
        data_we        = 1'b0;
        data_waddr     = '0;
        data_wdata     = req.fill_word;
        vict_step      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !busy)
                begin
                    if (req.op == OP_FILL)
                    begin
                        if (pend_reg)
                        begin
                            data_we    = 1'b1;
                            data_waddr = daddr(line_reg, fill_cnt_reg);
                            if (fill_cnt_reg == WIDX_W'(WPL - 1))
                            begin
                                valid_next[line_reg] = 1'b1;
                                dirty_next[line_reg] = 1'b0;
                                tag_we        = 1'b1;
                                fill_cnt_next = '0;
                                state_next    = ST_FRD;
                            end
                            else
                            begin
                                fill_cnt_next = fill_cnt_reg + 1'b1;
                            end
                        end
                    end
                    else if (req.op == OP_READ || req.op == OP_WRITE)
                    begin
                        if (pend_reg)
                        begin
                            rsp_valid_next   = 1'b1;
                            rsp_next.kind    = KIND_BUSY;
                            rsp_next.resp_id = req.req_id;
                            rsp_next.last    = 1'b1;
                        end
                        else
                        begin
                            req_next         = req;
                            req_next.address = req.address & AMASK;
                            tag_re           = 1'b1;
                            state_next       = ST_LOOK;
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                if (hit)
                begin
                    line_next  = line_of(cur_set, hit_way);
                    data_re    = 1'b1;
                    data_raddr = daddr(line_of(cur_set, hit_way), widx_of(req_reg.address));
                    state_next = ST_ACC;
                end
                else if (all_dirty)
                begin
                    vict_step   = 1'b1;
                    way_next    = vict_way;
                    line_next   = line_of(cur_set, vict_way);
                    wb_cnt_next = '0;
                    data_re     = 1'b1;
                    data_raddr  = daddr(line_of(cur_set, vict_way), '0);
                    state_next  = ST_WB;
                end
                else
                begin
                    way_next  = clean_way;
                    line_next = line_of(cur_set, clean_way);
                    valid_next[line_of(cur_set, clean_way)] = 1'b0;
                    dirty_next[line_of(cur_set, clean_way)] = 1'b0;
                    rsp_valid_next    = 1'b1;
                    rsp_next.kind     = KIND_FETCH;
                    rsp_next.mem_addr = req_reg.address & ~32'(LINE_BYTES - 1);
                    rsp_next.last     = 1'b1;
                    pend_next     = 1'b1;
                    fill_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_WB:
            begin
                rsp_valid_next    = 1'b1;
                rsp_next.kind     = KIND_WB;
                rsp_next.mem_addr = wb_addr;
                rsp_next.mem_word = data_rd_reg;
                if (wb_cnt_reg == WIDX_W'(WPL - 1))
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    wb_cnt_next = wb_cnt_reg + 1'b1;
                    data_re     = 1'b1;
                    data_raddr  = daddr(line_reg, wb_cnt_reg + 1'b1);
                end
            end
            ST_FETCH:
            begin
                valid_next[line_reg] = 1'b0;
                dirty_next[line_reg] = 1'b0;
                rsp_valid_next    = 1'b1;
                rsp_next.kind     = KIND_FETCH;
                rsp_next.mem_addr = req_reg.address & ~32'(LINE_BYTES - 1);
                rsp_next.last     = 1'b1;
                pend_next     = 1'b1;
                fill_cnt_next = '0;
                state_next    = ST_IDLE;
            end
            ST_FRD:
            begin
                // line fill completed last cycle, read the requested word back now
                data_re    = 1'b1;
                data_raddr = daddr(line_reg, widx_of(req_reg.address));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                rsp_valid_next   = 1'b1;
                rsp_next.resp_id = req_reg.req_id;
                rsp_next.last    = 1'b1;
                if (req_reg.op == OP_WRITE)
                begin
                    rsp_next.kind        = KIND_WACK;
                    data_we              = 1'b1;
                    data_waddr           = daddr(line_reg, widx_of(req_reg.address));
                    data_wdata           = merged;
                    dirty_next[line_reg] = 1'b1;
                end
                else
                begin
                    rsp_next.kind      = KIND_RDATA;
                    rsp_next.read_data = rd_bytes;
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            fill_cnt_reg  <= fill_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        line_reg <= line_next;
        way_reg  <= way_next;
        rsp_reg  <= rsp_next;
    end

    // tag store: one row per set, written one way at a time
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[cur_set][way_reg] <= cur_tag;
        end
        if (tag_re)
        begin
            tag_rd_reg <= tag_mem[set_of(req.address & AMASK)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (data_re)
        begin
            data_rd_reg <= data_mem[data_raddr];
        end
    end

    a_wb_from_wb_state: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.kind == KIND_WB) |-> $past(state_reg) == ST_WB)
        else $error("writeback word outside writeback sequence");

    a_fill_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> fill_cnt_reg == '0)
        else $error("fill count moved with no fetch outstanding");

    a_req_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !pend_reg && (req.op == OP_READ || req.op == OP_WRITE))
        |=> state_reg == ST_LOOK)
        else $error("accepted request did not enter lookup");

endmodule
